/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, sampled on clk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every clock edge outside reset
`define SFP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// cond must never be true outside reset
`define SFP_ASSERT_NEVER(lbl, cond, msg) \
	`SFP_ASSERT(lbl, !(cond), msg)

`endif

/* rtl/core/sfp_pkg.sv */
// ----------------------------------------------------------------------------
// sfp_pkg
// Types, frame codes and fixed-point helpers of the sensor frame parser.
// ----------------------------------------------------------------------------
package sfp_pkg;

	localparam int NUM_KINDS = 5;
	localparam int AXES      = 3;

	localparam logic [2:0] KIND_ACCEL = 3'd0;
	localparam logic [2:0] KIND_EMG   = 3'd1;
	localparam logic [2:0] KIND_SPO2  = 3'd2;
	localparam logic [2:0] KIND_TEMP  = 3'd3;
	localparam logic [2:0] KIND_MAG   = 3'd4;

	localparam logic [7:0] TAIL_BYTE = 8'h5C;

	localparam int MAG_CALIB_FRAMES = 10;
	localparam int CALIB_W          = 4;

	// offset average: round(|s| / N) = floor((|s| + N/2) * M >> DIV_SHIFT), exact for 24 bits
	localparam int DIV_SHIFT  = 24 + $clog2(MAG_CALIB_FRAMES);
	localparam int DIV_MULT_W = 26;
	localparam int PROD_W     = 24 + DIV_MULT_W;
	localparam logic [DIV_MULT_W-1:0] DIV_MULT = DIV_MULT_W'(
		((64'd1 << DIV_SHIFT) + 64'(MAG_CALIB_FRAMES) - 64'd1) / 64'(MAG_CALIB_FRAMES));
	localparam logic [23:0] DIV_BIAS = 24'(MAG_CALIB_FRAMES / 2);

	typedef logic signed [23:0] v24_t;
	typedef logic [5:0][7:0] payload_t;

	typedef struct packed {
		logic [2:0] kind;
		payload_t   pay;
	} frame_t;

	typedef struct packed {
		logic       calibrating;
		logic [2:0] kind;
		v24_t       z;
		v24_t       y;
		v24_t       x;
	} res_t;

	function automatic logic [7:0] hdr_code(input logic [2:0] kind);
		case (kind)
			KIND_ACCEL: return 8'h51;
			KIND_EMG:   return 8'h53;
			KIND_SPO2:  return 8'h55;
			KIND_TEMP:  return 8'h57;
			KIND_MAG:   return 8'h59;
			default:    return 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] id_code(input logic [2:0] kind);
		case (kind)
			KIND_ACCEL: return 8'hF1;
			KIND_EMG:   return 8'hF3;
			KIND_SPO2:  return 8'hF5;
			KIND_TEMP:  return 8'hF7;
			KIND_MAG:   return 8'hF9;
			default:    return 8'h00;
		endcase
	endfunction

	function automatic logic [3:0] pay_len(input logic [2:0] kind);
		case (kind)
			KIND_ACCEL: return 4'd9;
			KIND_EMG:   return 4'd3;
			KIND_SPO2:  return 4'd6;
			KIND_TEMP:  return 4'd2;
			KIND_MAG:   return 4'd6;
			default:    return 4'd0;
		endcase
	endfunction

	function automatic v24_t be16(input logic [7:0] hi, input logic [7:0] lo);
		return {{8{hi[7]}}, hi, lo};
	endfunction

	function automatic v24_t be24(input logic [7:0] hi, input logic [7:0] mid,
		input logic [7:0] lo);
		return {hi, mid, lo};
	endfunction

	// Q.4 raw magnetometer sample
	function automatic v24_t mag_raw(input logic [7:0] hi, input logic [7:0] lo);
		return {{4{hi[7]}}, hi, lo, 4'b0000};
	endfunction

	function automatic v24_t sat24(input logic signed [25:0] v);
		if (v[25:23] == 3'b000 || v[25:23] == 3'b111) begin
			return v[23:0];
		end
		return v[25] ? 24'h800000 : 24'h7FFFFF;
	endfunction

endpackage

/* rtl/core/sfp_parser.sv */
// ----------------------------------------------------------------------------
// sfp_parser
// Byte-serial frame state machine: header, id, payload, checksum, tail.
// ----------------------------------------------------------------------------
module sfp_parser import sfp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_take,
	input  logic [7:0] rx_byte,
	output logic       tail_phase,
	output logic       frm_done,
	output frame_t     frm
);

	localparam logic [2:0] PH_HDR  = 3'd0;
	localparam logic [2:0] PH_ID   = 3'd1;
	localparam logic [2:0] PH_PAY  = 3'd2;
	localparam logic [2:0] PH_CHK  = 3'd3;
	localparam logic [2:0] PH_TAIL = 3'd4;

	logic [2:0] phase_q;
	logic [2:0] kind_q;
	logic [3:0] left_q;
	logic [3:0] pos_q;
	logic [7:0] sum_q;
	logic [7:0] check_q;
	payload_t   pay_q;

	logic       hdr_hit;
	logic [2:0] hdr_kind;
	logic [3:0] left_dec;

	always_comb begin
		hdr_hit  = 1'b0;
		hdr_kind = 3'd0;
		for (int k = 0; k < NUM_KINDS; k++) begin
			if (rx_byte == hdr_code(3'(k))) begin
				hdr_hit  = 1'b1;
				hdr_kind = 3'(k);
			end
		end
	end

	assign left_dec   = left_q - 4'd1;
	assign tail_phase = (phase_q == PH_TAIL);
	assign frm_done   = in_take && tail_phase && (rx_byte == TAIL_BYTE) &&
		(kind_q <= KIND_MAG) && ((kind_q == KIND_MAG) || (sum_q == check_q));
	assign frm.kind   = kind_q;
	assign frm.pay    = pay_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR;
			kind_q  <= 3'd0;
			left_q  <= 4'd0;
			pos_q   <= 4'd0;
			sum_q   <= 8'd0;
			check_q <= 8'd0;
		end else if (in_take) begin
			case (phase_q)
				PH_ID: begin
					if (kind_q <= KIND_MAG && rx_byte == id_code(kind_q)) begin
						sum_q   <= sum_q + rx_byte;
						left_q  <= pay_len(kind_q);
						pos_q   <= 4'd0;
						phase_q <= PH_PAY;
					end else begin
						phase_q <= PH_HDR;
					end
				end
				PH_PAY: begin
					sum_q  <= sum_q + rx_byte;
					pos_q  <= pos_q + 4'd1;
					left_q <= left_dec;
					if (left_dec == 4'd0) begin
						phase_q <= PH_CHK;
					end
				end
				PH_CHK: begin
					check_q <= rx_byte;
					phase_q <= PH_TAIL;
				end
				PH_TAIL: begin
					phase_q <= PH_HDR;
				end
				default: begin
					if (hdr_hit) begin
						kind_q  <= hdr_kind;
						sum_q   <= rx_byte;
						phase_q <= PH_ID;
					end
				end
			endcase
		end
	end

	// only the first six payload bytes are kept
	always_ff @(posedge clk) begin
		if (in_take && phase_q == PH_PAY && pos_q < 4'd6) begin
			pay_q[pos_q[2:0]] <= rx_byte;
		end
	end

endmodule

/* rtl/core/sfp_mag_div.sv */
// ----------------------------------------------------------------------------
// sfp_mag_div
// Two-stage rounded divide of the offset sums by the calibration frame count.
// ----------------------------------------------------------------------------
module sfp_mag_div import sfp_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  v24_t        sum [AXES],
	output logic [23:0] quo [AXES],
	output logic        neg [AXES]
);

	logic              neg_s3  [AXES];
	logic [23:0]       mag_s3  [AXES];
	logic              neg_s4  [AXES];
	logic [PROD_W-1:0] prod_s4 [AXES];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < AXES; a++) begin
				neg_s3[a]  <= sum[a][23];
				mag_s3[a]  <= (sum[a][23] ? 24'(-sum[a]) : 24'(sum[a])) + DIV_BIAS;
				neg_s4[a]  <= neg_s3[a];
				prod_s4[a] <= mag_s3[a] * DIV_MULT;
			end
		end
	end

	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			quo[a] = 24'(prod_s4[a] >> DIV_SHIFT);
			neg[a] = neg_s4[a];
		end
	end

endmodule

/* rtl/core/sfp_result.sv */
// ----------------------------------------------------------------------------
// sfp_result
// Frame capture, value decode, magnetometer offset learning and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sfp_result import sfp_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   frm_done,
	input  frame_t frm,
	output logic   s1_busy,
	output logic   out_valid,
	input  logic   out_ready,
	output res_t   out_res
);

	localparam logic [1:0] MODE_RAW  = 2'd0;
	localparam logic [1:0] MODE_SUM  = 2'd1;
	localparam logic [1:0] MODE_DIV  = 2'd2;
	localparam logic [1:0] MODE_LIVE = 2'd3;

	logic en;

	logic   valid_s1;
	frame_t frm_s1;

	logic       valid_s2, valid_s3, valid_s4;
	logic [2:0] kind_s2, kind_s3, kind_s4;
	logic       cal_s2, cal_s3, cal_s4;
	logic [1:0] mode_s2, mode_s3, mode_s4;
	v24_t       r_s2 [AXES];
	v24_t       r_s3 [AXES];
	v24_t       r_s4 [AXES];
	v24_t       off_s2 [AXES];
	v24_t       off_s3 [AXES];
	v24_t       off_s4 [AXES];

	logic [CALIB_W-1:0] calib_q;
	v24_t               mag_offset_q [AXES];

	logic               out_valid_q;
	res_t               out_res_q;

	v24_t               raw_v [AXES];
	v24_t               sum_v [AXES];
	logic               cal_active;
	logic [CALIB_W-1:0] calib_next;
	logic [1:0]         mode_v;

	logic [23:0] quo   [AXES];
	logic        neg   [AXES];
	v24_t        div_v [AXES];
	v24_t        opnd  [AXES];
	v24_t        val   [AXES];

	assign en      = !out_valid_q || out_ready;
	assign s1_busy = valid_s1 && !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frm_done) begin
			valid_s1 <= 1'b1;
		end else if (en) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (frm_done) begin
			frm_s1 <= frm;
		end
	end

	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			raw_v[a] = '0;
		end
		case (frm_s1.kind)
			KIND_ACCEL: begin
				raw_v[0] = be16(frm_s1.pay[0], frm_s1.pay[1]);
				raw_v[1] = be16(frm_s1.pay[2], frm_s1.pay[3]);
				raw_v[2] = be16(frm_s1.pay[4], frm_s1.pay[5]);
			end
			KIND_EMG: begin
				raw_v[0] = be24(frm_s1.pay[0], frm_s1.pay[1], frm_s1.pay[2]);
			end
			KIND_SPO2: begin
				raw_v[0] = be24(frm_s1.pay[0], frm_s1.pay[1], frm_s1.pay[2]);
				raw_v[1] = be24(frm_s1.pay[3], frm_s1.pay[4], frm_s1.pay[5]);
			end
			KIND_TEMP: begin
				raw_v[0] = be16(frm_s1.pay[0], frm_s1.pay[1]);
			end
			KIND_MAG: begin
				raw_v[0] = mag_raw(frm_s1.pay[0], frm_s1.pay[1]);
				raw_v[1] = mag_raw(frm_s1.pay[2], frm_s1.pay[3]);
				raw_v[2] = mag_raw(frm_s1.pay[4], frm_s1.pay[5]);
			end
			default: begin
			end
		endcase

		for (int a = 0; a < AXES; a++) begin
			sum_v[a] = sat24(26'(mag_offset_q[a]) + 26'(raw_v[a]));
		end

		cal_active = valid_s1 && (frm_s1.kind == KIND_MAG) &&
			(calib_q < CALIB_W'(MAG_CALIB_FRAMES));
		calib_next = cal_active ? calib_q + CALIB_W'(1) : calib_q;

		if (frm_s1.kind != KIND_MAG) begin
			mode_v = MODE_RAW;
		end else if (cal_active) begin
			mode_v = (calib_next == CALIB_W'(MAG_CALIB_FRAMES)) ? MODE_DIV : MODE_SUM;
		end else begin
			mode_v = MODE_LIVE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			calib_q  <= '0;
		end else if (en) begin
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			calib_q  <= calib_next;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s2 <= frm_s1.kind;
			cal_s2  <= (calib_next < CALIB_W'(MAG_CALIB_FRAMES));
			mode_s2 <= mode_v;
			kind_s3 <= kind_s2;
			cal_s3  <= cal_s2;
			mode_s3 <= mode_s2;
			kind_s4 <= kind_s3;
			cal_s4  <= cal_s3;
			mode_s4 <= mode_s3;
			for (int a = 0; a < AXES; a++) begin
				r_s2[a]   <= raw_v[a];
				off_s2[a] <= (mode_v == MODE_SUM || mode_v == MODE_DIV) ? sum_v[a] : '0;
				r_s3[a]   <= r_s2[a];
				off_s3[a] <= off_s2[a];
				r_s4[a]   <= r_s3[a];
				off_s4[a] <= off_s3[a];
			end
		end
	end

	sfp_mag_div u_div (
		.clk (clk),
		.en  (en),
		.sum (off_s2),
		.quo (quo),
		.neg (neg)
	);

	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			div_v[a] = neg[a] ? 24'(-quo[a]) : quo[a];
			case (mode_s4)
				MODE_DIV:  opnd[a] = div_v[a];
				MODE_LIVE: opnd[a] = mag_offset_q[a];
				default:   opnd[a] = off_s4[a];
			endcase
			val[a] = sat24(26'(r_s4[a]) - 26'(opnd[a]));
		end
	end

	// running sum while learning, average once on the last learning frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < AXES; a++) begin
				mag_offset_q[a] <= '0;
			end
		end else if (en && cal_active) begin
			for (int a = 0; a < AXES; a++) begin
				mag_offset_q[a] <= sum_v[a];
			end
		end else if (en && valid_s4 && mode_s4 == MODE_DIV) begin
			for (int a = 0; a < AXES; a++) begin
				mag_offset_q[a] <= div_v[a];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_res_q.kind        <= kind_s4;
			out_res_q.calibrating <= cal_s4;
			out_res_q.x           <= val[0];
			out_res_q.y           <= val[1];
			out_res_q.z           <= val[2];
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

	`SFP_ASSERT(a_calib_bound, calib_q <= CALIB_W'(MAG_CALIB_FRAMES), "calibration count overrun")
	`SFP_ASSERT(a_calib_step, 1'b1 |=> (calib_q == $past(calib_q) || calib_q == $past(calib_q) + CALIB_W'(1)), "calibration count jumped")
	`SFP_ASSERT(a_div_done, valid_s4 && mode_s4 == MODE_DIV |-> calib_q == CALIB_W'(MAG_CALIB_FRAMES), "average taken before learning ended")
	`SFP_ASSERT_NEVER(a_s1_overrun, frm_done && valid_s1 && !en, "capture stage overwritten")

endmodule

/* rtl/core/sensor_frame_parser_core.sv */
// ----------------------------------------------------------------------------
// sensor_frame_parser_core
// Sensor frame parser: one stream byte per cycle in, one decoded result per valid frame.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle; tready drops only when a tail byte meets a full
//   capture stage behind a stalled result register.
// Pipeline: an accepted tail byte moves through capture, decode, divide bias,
//   divide multiply and the result register before the result is valid.
// Reset: arst_n clears frame state, offsets and calibration count; no clearing pass.
module sensor_frame_parser_core import sfp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,   // [23:0] value_x, [47:24] value_y, [71:48] value_z
	output logic [3:0]  m_axis_tuser    // [2:0] sensor_kind, [3] calibrating
);

	logic   in_take;
	logic   tail_phase;
	logic   frm_done;
	frame_t frm;
	logic   s1_busy;
	res_t   res;

	assign s_axis_tready = !(tail_phase && s1_busy);
	assign in_take       = s_axis_tvalid && s_axis_tready;

	sfp_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_take    (in_take),
		.rx_byte    (s_axis_tdata),
		.tail_phase (tail_phase),
		.frm_done   (frm_done),
		.frm        (frm)
	);

	sfp_result u_result (
		.clk       (clk),
		.arst_n    (arst_n),
		.frm_done  (frm_done),
		.frm       (frm),
		.s1_busy   (s1_busy),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (res)
	);

	assign m_axis_tdata = {res.z, res.y, res.x};
	assign m_axis_tuser = {res.calibrating, res.kind};

endmodule

/* sim/tb_sensor_frame_parser_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sensor_frame_parser_core
// Byte-stream test of the sensor frame parser. Directed frames cover the
// special cases: stray bytes, id mismatch, bad checksum and sample extremes.
// Random frames of all five kinds follow, some of them broken, with sender
// bursts and receiver stalls. Each decoded reading is checked field by field
// against readings predicted in the testbench, including the magnetometer
// offset learning.
// ----------------------------------------------------------------------------
module tb_sensor_frame_parser_core;
	import sfp_pkg::*;

	localparam int IDLE_LIMIT    = 4000;
	localparam int SETTLE_CYCLES = 20;
	localparam int STREAM_BYTES  = 1000;
	localparam int DRAIN_EVERY   = 300;

	localparam logic [4:0][7:0] HEADER_CODE = {8'h59, 8'h57, 8'h55, 8'h53, 8'h51};
	localparam logic [4:0][7:0] ID_CODE     = {8'hF9, 8'hF7, 8'hF5, 8'hF3, 8'hF1};
	localparam logic [4:0][3:0] PAYLOAD_LEN = {4'd6, 4'd2, 4'd6, 4'd3, 4'd9};

	typedef enum logic [2:0] {PH_HEADER, PH_ID, PH_PAYLOAD, PH_CHECK, PH_TAIL} parse_phase_e;
	typedef enum int {FLAW_NONE, FLAW_ID, FLAW_CHECK, FLAW_TAIL, FLAW_SHORT} flaw_e;

	class reading_board;
		parse_phase_e phase = PH_HEADER;
		logic [2:0]   kind = '0;
		logic [3:0]   left = '0;
		logic [3:0]   pos = '0;
		logic [7:0]   sum = '0;
		logic [7:0]   got_check = '0;
		logic [7:0]   pay [6];
		int           offset [3];
		int           calib = 0;
		res_t         pending_readings [$];
		int           errors = 0;

		function int word16(int i);
			return int'($signed({pay[i], pay[i+1]}));
		endfunction

		function int word24(int i);
			logic signed [23:0] v;
			v = {pay[i], pay[i+1], pay[i+2]};
			return int'(v);
		endfunction

		function int clip24(int v);
			if (v > 8388607) begin
				return 8388607;
			end
			if (v < -8388608) begin
				return -8388608;
			end
			return v;
		endfunction

		function int round_average(int s);
			longint a;
			longint q;
			a = (s < 0) ? -longint'(s) : longint'(s);
			q = (2 * a + MAG_CALIB_FRAMES) / (2 * MAG_CALIB_FRAMES);
			return (s < 0) ? -int'(q) : int'(q);
		endfunction

		function res_t decode_reading();
			res_t r;
			int   raw [3];
			r = '0;
			r.kind = kind;
			case (kind)
				KIND_ACCEL: begin
					r.x = 24'(word16(0));
					r.y = 24'(word16(2));
					r.z = 24'(word16(4));
				end
				KIND_EMG: begin
					r.x = 24'(word24(0));
				end
				KIND_SPO2: begin
					r.x = 24'(word24(0));
					r.y = 24'(word24(3));
				end
				KIND_TEMP: begin
					r.x = 24'(word16(0));
				end
				default: begin
					for (int k = 0; k < 3; k++) begin
						raw[k] = word16(2 * k) * 16;
					end
					if (calib < MAG_CALIB_FRAMES) begin
						for (int k = 0; k < 3; k++) begin
							offset[k] = clip24(offset[k] + raw[k]);
						end
						calib++;
						if (calib == MAG_CALIB_FRAMES) begin
							for (int k = 0; k < 3; k++) begin
								offset[k] = round_average(offset[k]);
							end
						end
					end
					r.x = 24'(clip24(raw[0] - offset[0]));
					r.y = 24'(clip24(raw[1] - offset[1]));
					r.z = 24'(clip24(raw[2] - offset[2]));
				end
			endcase
			r.calibrating = (calib < MAG_CALIB_FRAMES);
			return r;
		endfunction

		function void take_byte(logic [7:0] b);
			res_t fresh;
			case (phase)
				PH_ID: begin
					if (b == ID_CODE[kind]) begin
						sum   = sum + b;
						left  = PAYLOAD_LEN[kind];
						pos   = '0;
						phase = PH_PAYLOAD;
					end else begin
						phase = PH_HEADER;
					end
				end
				PH_PAYLOAD: begin
					sum = sum + b;
					if (pos < 6) begin
						pay[pos[2:0]] = b;
					end
					pos  = pos + 4'd1;
					left = left - 4'd1;
					if (left == 0) begin
						phase = PH_CHECK;
					end
				end
				PH_CHECK: begin
					got_check = b;
					phase     = PH_TAIL;
				end
				PH_TAIL: begin
					phase = PH_HEADER;
					if (b == TAIL_BYTE && (kind == KIND_MAG || sum == got_check)) begin
						fresh            = decode_reading();
						pending_readings = {pending_readings, fresh};
					end
				end
				default: begin
					for (int k = 0; k < NUM_KINDS; k++) begin
						if (b == HEADER_CODE[k]) begin
							kind  = 3'(k);
							sum   = b;
							phase = PH_ID;
						end
					end
				end
			endcase
		endfunction

		task report_error(string msg);
			$display("ERROR at %0t ns: %s", $time, msg);
			errors++;
		endtask

		task compare_field(string name, logic [23:0] got, logic [23:0] want);
			if (got !== want) begin
				report_error($sformatf("%s got %0h expected %0h", name, got, want));
			end
		endtask

		task check_reading(res_t got);
			res_t want;
			if (pending_readings.size() == 0) begin
				report_error($sformatf("reading with none pending, kind %0d", got.kind));
				return;
			end
			want = pending_readings.pop_front();
			compare_field("sensor_kind", 24'(got.kind), 24'(want.kind));
			compare_field("value_x", got.x, want.x);
			compare_field("value_y", got.y, want.y);
			compare_field("value_z", got.z, want.z);
			compare_field("calibrating", 24'(got.calibrating), 24'(want.calibrating));
		endtask

		function int pending();
			return pending_readings.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [71:0] m_axis_tdata;
	logic [3:0]  m_axis_tuser;

	reading_board board = new();
	int           idle_cycles = 0;
	int           burst_left = 0;
	int           bytes_sent = 0;

	sensor_frame_parser_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			board.take_byte(s_axis_tdata);
		end
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			board.check_reading(res_t'({m_axis_tuser, m_axis_tdata}));
		end
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// receiver: stall pattern picks a new random mode after each span
	initial begin
		int mode;
		int span;
		int tick;
		tick = 0;
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(10, 120);
			repeat (span) begin
				@(negedge clk);
				tick++;
				case (mode)
					0:       m_axis_tready <= 1'b1;
					1:       m_axis_tready <= 1'($urandom_range(0, 1));
					2:       m_axis_tready <= ($urandom_range(0, 7) == 0);
					default: m_axis_tready <= (tick % 5 == 0);
				endcase
			end
		end
	end

	// one request per call; returns at the accepting edge with tvalid still high
	task automatic push_byte(input logic [7:0] b);
		@(negedge clk);
		if (burst_left == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
				: $urandom_range(1, 12);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		do @(posedge clk); while (!s_axis_tready);
		burst_left--;
		bytes_sent++;
	endtask

	task automatic drain_readings();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
	endtask

	function automatic logic [7:0] payload_byte();
		case ($urandom_range(0, 7))
			0:       return 8'h00;
			1:       return 8'hFF;
			2:       return 8'h7F;
			3:       return 8'h80;
			default: return 8'($urandom);
		endcase
	endfunction

	// often a header code, to check it is not taken as a new frame start
	function automatic logic [7:0] wrong_byte(input logic [7:0] right);
		logic [7:0] b;
		do begin
			b = ($urandom_range(0, 1) == 0) ? HEADER_CODE[$urandom_range(0, NUM_KINDS - 1)]
				: 8'($urandom);
		end while (b == right);
		return b;
	endfunction

	task automatic send_frame(input logic [2:0] kind, input logic [8:0][7:0] pay,
		input flaw_e flaw);
		logic [7:0] sum;
		int         cut;
		sum = HEADER_CODE[kind];
		push_byte(HEADER_CODE[kind]);
		if (flaw == FLAW_ID) begin
			push_byte(wrong_byte(ID_CODE[kind]));
			return;
		end
		push_byte(ID_CODE[kind]);
		sum = sum + ID_CODE[kind];
		cut = (flaw == FLAW_SHORT) ? $urandom_range(0, PAYLOAD_LEN[kind] - 1)
			: int'(PAYLOAD_LEN[kind]);
		for (int n = 0; n < cut; n++) begin
			sum = sum + pay[n];
			push_byte(pay[n]);
		end
		if (flaw == FLAW_SHORT) begin
			return;
		end
		push_byte((flaw == FLAW_CHECK) ? (sum ^ 8'($urandom_range(1, 255))) : sum);
		push_byte((flaw == FLAW_TAIL) ? wrong_byte(TAIL_BYTE) : TAIL_BYTE);
	endtask

	task automatic send_random_frame();
		logic [8:0][7:0] pay;
		logic [2:0]      kind;
		flaw_e           flaw;
		int              pick;
		for (int n = 0; n < 9; n++) begin
			pay[n] = payload_byte();
		end
		kind = ($urandom_range(0, 5) == 5) ? KIND_MAG : 3'($urandom_range(0, NUM_KINDS - 1));
		pick = $urandom_range(0, 19);
		if (pick < 14) begin
			flaw = FLAW_NONE;
		end else if (pick < 15) begin
			flaw = FLAW_ID;
		end else if (pick < 17) begin
			flaw = FLAW_CHECK;
		end else if (pick < 19) begin
			flaw = FLAW_TAIL;
		end else begin
			flaw = FLAW_SHORT;
		end
		send_frame(kind, pay, flaw);
	endtask

	initial begin
		int next_drain;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// stray bytes, then an id mismatch whose id byte is a header code
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(HEADER_CODE[KIND_EMG]);
		push_byte(HEADER_CODE[KIND_TEMP]);
		push_byte(ID_CODE[KIND_TEMP]);
		send_frame(KIND_TEMP, {56'h0, 8'h00, 8'h80}, FLAW_NONE);
		send_frame(KIND_EMG, {48'h0, 8'hFF, 8'hFF, 8'h7F}, FLAW_CHECK);
		// magnetometer ignores the checksum
		send_frame(KIND_MAG, {24'h0, 8'h00, 8'h00, 8'hFF, 8'h7F, 8'h00, 8'h80}, FLAW_CHECK);
		drain_readings();

		next_drain = bytes_sent + DRAIN_EVERY;
		while (bytes_sent < STREAM_BYTES) begin
			if ($urandom_range(0, 9) == 0) begin
				push_byte(8'($urandom));
			end else begin
				send_random_frame();
			end
			if (bytes_sent >= next_drain) begin
				drain_readings();
				next_drain = bytes_sent + DRAIN_EVERY;
			end
		end
		drain_readings();
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (board.errors == 0 && board.pending() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
